// File: src/ctsf_pkg.sv
package ctsf_pkg;

	localparam int NCFG      = 8;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_SEL_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_ALL        = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ENDS_AND_NONPRINT = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ENDS_ONLY         = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TABS_AND_NONPRINT = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TABS_ONLY         = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINT     = 4'd7;

	// line number stops at 999999
	localparam int CAP_DIGITS = 6;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DEL    = 8'd127;
	localparam logic [7:0] CTRL_MAX  = 8'd31;
	localparam logic [7:0] CARET_OFS = 8'd64;

	typedef logic [3:0] bcd_t;

	typedef struct packed {
		logic upd;
		logic clr;
		logic inc;
	} lnum_ctl_t;

	typedef struct packed {
		logic [7:0] c0;
		logic [7:0] c1;
		logic       two;
	} vis_t;

	function automatic vis_t visible(input logic [7:0] b);
		vis_t v;
		v.c0  = b;
		v.c1  = b;
		v.two = 1'b0;
		if ((b > CTRL_MAX && b < CH_DEL) || b == CH_NL || b == CH_TAB) begin
			v.two = 1'b0;
		end else if (b == CH_DEL) begin
			v.c0  = CH_CARET;
			v.c1  = CH_QMARK;
			v.two = 1'b1;
		end else begin
			v.c0  = CH_CARET;
			v.c1  = b + CARET_OFS;
			v.two = 1'b1;
		end
		return v;
	endfunction

endpackage

// File: src/ctsf_in_if.sv
interface ctsf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_of_file;

	modport source(output valid, output data_byte, output first_of_file, input ready);
	modport sink(input valid, input data_byte, input first_of_file, output ready);
endinterface

// File: src/ctsf_out_if.sv
interface ctsf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source(output valid, output out_byte, output last, input ready);
	modport sink(input valid, input out_byte, input last, output ready);
endinterface

// File: src/ctsf_cfg_if.sv
interface ctsf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ctsf_pkg::CFG_IDX_W-1:0] index;
	logic                           data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// File: src/cat_text_stream_formatter.sv
// channel  | dir | payload                       | transfer when
// in_ch    | in  | data_byte[7:0], first_of_file | in_ch.valid && in_ch.ready
// out_ch   | out | out_byte[7:0], last           | out_ch.valid && out_ch.ready
// cfg      | in  | index[3:0], data              | cfg.valid && cfg.ready
//
// Each input byte is formatted into an output buffer of up to NUMBER_DIGITS+3
// bytes, which then drains one byte per cycle on out_ch while out_ch.ready is high.
// The output port sets the rate.
// in_ch.ready is high when the buffer is empty or its last byte leaves now.
// arst_n clears config, line number, blank run and the buffer count; previous byte resets to newline.
// cfg.ready is always high.
module cat_text_stream_formatter #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	ctsf_in_if.sink           in_ch,
	ctsf_out_if.source        out_ch,
	ctsf_cfg_if.sink          cfg
);

	localparam int EFF   = (NUMBER_DIGITS < ctsf_pkg::CAP_DIGITS) ?
	                       NUMBER_DIGITS : ctsf_pkg::CAP_DIGITS;
	localparam int MAXB  = NUMBER_DIGITS + 3;
	localparam int CNT_W = $clog2(MAXB + 1);

	logic [ctsf_pkg::NCFG-1:0] cfg_q;
	logic [7:0]                prev_q;
	logic [1:0]                br_q;
	logic [7:0]                buf_q [MAXB];
	logic [CNT_W-1:0]          cnt_q;

	logic                nonblank, numall, squeeze, en, eo, tn, to, vn;
	logic [7:0]          b;
	logic                ff, prev_nl, in_xfer, out_xfer;
	logic                ln_zero, num_emit, sq_emit, main_emit;
	logic [1:0]          br_new;
	ctsf_pkg::lnum_ctl_t lctl;
	ctsf_pkg::bcd_t      digits [EFF];
	logic [EFF-1:0]      nzab;
	ctsf_pkg::vis_t      vis, chr;
	logic [7:0]          tail [3];
	logic [1:0]          tc;
	logic [7:0]          buf_d [MAXB];
	logic [CNT_W-1:0]    tot;

	assign nonblank = cfg_q[ctsf_pkg::CFG_NUMBER_NONBLANK[ctsf_pkg::CFG_SEL_W-1:0]];
	assign numall   = cfg_q[ctsf_pkg::CFG_NUMBER_ALL[ctsf_pkg::CFG_SEL_W-1:0]];
	assign squeeze  = cfg_q[ctsf_pkg::CFG_SQUEEZE_BLANK[ctsf_pkg::CFG_SEL_W-1:0]];
	assign en       = cfg_q[ctsf_pkg::CFG_ENDS_AND_NONPRINT[ctsf_pkg::CFG_SEL_W-1:0]];
	assign eo       = cfg_q[ctsf_pkg::CFG_ENDS_ONLY[ctsf_pkg::CFG_SEL_W-1:0]];
	assign tn       = cfg_q[ctsf_pkg::CFG_TABS_AND_NONPRINT[ctsf_pkg::CFG_SEL_W-1:0]];
	assign to       = cfg_q[ctsf_pkg::CFG_TABS_ONLY[ctsf_pkg::CFG_SEL_W-1:0]];
	assign vn       = cfg_q[ctsf_pkg::CFG_SHOW_NONPRINT[ctsf_pkg::CFG_SEL_W-1:0]];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid && cfg.index < ctsf_pkg::CFG_IDX_W'(ctsf_pkg::NCFG)) begin
			cfg_q[cfg.index[ctsf_pkg::CFG_SEL_W-1:0]] <= cfg.data;
		end
	end

	assign b        = in_ch.data_byte;
	assign ff       = in_ch.first_of_file;
	assign prev_nl  = ff || prev_q == ctsf_pkg::CH_NL;
	assign in_ch.ready = (cnt_q == '0) || (cnt_q == CNT_W'(1) && out_ch.ready);
	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign out_xfer = out_ch.valid && out_ch.ready;

	assign lctl.upd = in_xfer;
	assign lctl.clr = ff;
	assign lctl.inc = num_emit;

	ctsf_line_counter #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_line_counter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lctl),
		.zero   (ln_zero),
		.nxt    (digits)
	);

	always_comb begin
		if (nonblank)
			num_emit = b != ctsf_pkg::CH_NL && (ln_zero || prev_nl);
		else if (numall)
			num_emit = ln_zero || (prev_nl && br_q < 2'd2);
		else
			num_emit = 1'b0;

		if (!squeeze)
			br_new = br_q;
		else if (prev_nl && b == ctsf_pkg::CH_NL)
			br_new = (br_q == 2'd3) ? 2'd3 : br_q + 2'd1;
		else
			br_new = 2'd0;

		sq_emit   = squeeze && br_new == 2'd1;
		main_emit = !squeeze || br_new == 2'd0;
	end

	always_comb begin
		vis = ctsf_pkg::visible(b);
		chr = '{c0: b, c1: b, two: 1'b0};
		if (tn || to) begin
			if (b == ctsf_pkg::CH_TAB)
				chr = '{c0: ctsf_pkg::CH_CARET, c1: ctsf_pkg::CH_I, two: 1'b1};
			else if (!(to && !vn))
				chr = vis;
		end else if (en || vn) begin
			chr = vis;
		end

		tail[0] = chr.c0;
		tail[1] = chr.c1;
		tail[2] = chr.c1;
		tc      = 2'd0;
		if (sq_emit) begin
			if (en || eo) begin
				tail[0] = ctsf_pkg::CH_DOLLAR;
				tail[1] = ctsf_pkg::CH_NL;
				tc      = 2'd2;
			end else begin
				tail[0] = ctsf_pkg::CH_NL;
				tc      = 2'd1;
			end
		end else if (main_emit) begin
			if ((en || eo) && b == ctsf_pkg::CH_NL) begin
				tail[0] = ctsf_pkg::CH_DOLLAR;
				tail[1] = chr.c0;
				tail[2] = chr.c1;
				tc      = chr.two ? 2'd3 : 2'd2;
			end else begin
				tc      = chr.two ? 2'd2 : 2'd1;
			end
		end
	end

	// nonzero digit at this weight or above
	always_comb begin
		nzab[EFF-1] = digits[EFF-1] != 4'd0;
		for (int w = EFF - 2; w >= 0; w--)
			nzab[w] = nzab[w+1] || digits[w] != 4'd0;
	end

	always_comb begin
		for (int i = 0; i < MAXB; i++) begin
			buf_d[i] = 8'h00;
			if (num_emit) begin
				if (i < NUMBER_DIGITS) begin
					if (NUMBER_DIGITS - 1 - i >= EFF)
						buf_d[i] = ctsf_pkg::CH_SPACE;
					else if (NUMBER_DIGITS - 1 - i > 0 && !nzab[NUMBER_DIGITS - 1 - i])
						buf_d[i] = ctsf_pkg::CH_SPACE;
					else
						buf_d[i] = ctsf_pkg::CH_ZERO + {4'd0, digits[NUMBER_DIGITS - 1 - i]};
				end else if (i == NUMBER_DIGITS) begin
					buf_d[i] = ctsf_pkg::CH_TAB;
				end else begin
					buf_d[i] = tail[i - NUMBER_DIGITS - 1];
				end
			end else if (i < 3) begin
				buf_d[i] = tail[i];
			end
		end
		tot = (num_emit ? CNT_W'(NUMBER_DIGITS + 1) : CNT_W'(0)) + CNT_W'(tc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= ctsf_pkg::CH_NL;
			br_q   <= 2'd0;
		end else if (in_xfer) begin
			br_q <= br_new;
			if (main_emit)
				prev_q <= b;
			else if (ff)
				prev_q <= ctsf_pkg::CH_NL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_xfer) begin
			cnt_q <= tot;
		end else if (out_xfer) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			buf_q <= buf_d;
		end else if (out_xfer) begin
			for (int i = 0; i < MAXB - 1; i++)
				buf_q[i] <= buf_q[i+1];
		end
	end

	assign out_ch.valid    = cnt_q != '0;
	assign out_ch.out_byte = buf_q[0];
	assign out_ch.last     = cnt_q == CNT_W'(1);

endmodule

// File: src/ctsf_line_counter.sv
module ctsf_line_counter #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctsf_pkg::lnum_ctl_t ctl,
	output logic                zero,
	output ctsf_pkg::bcd_t      nxt [(NUMBER_DIGITS < ctsf_pkg::CAP_DIGITS) ?
	                                 NUMBER_DIGITS : ctsf_pkg::CAP_DIGITS]
);

	localparam int EFF = (NUMBER_DIGITS < ctsf_pkg::CAP_DIGITS) ?
	                     NUMBER_DIGITS : ctsf_pkg::CAP_DIGITS;

	ctsf_pkg::bcd_t cnt_q [EFF];
	ctsf_pkg::bcd_t start [EFF];
	logic           all9;
	logic           carry;

	// digit 0 is least significant; saturates at all nines
	always_comb begin
		all9  = 1'b1;
		zero  = 1'b1;
		carry = 1'b1;
		for (int i = 0; i < EFF; i++) begin
			start[i] = ctl.clr ? 4'd0 : cnt_q[i];
			if (start[i] != 4'd9)
				all9 = 1'b0;
			if (start[i] != 4'd0)
				zero = 1'b0;
		end
		for (int i = 0; i < EFF; i++) begin
			if (all9 || !carry) begin
				nxt[i] = start[i];
			end else if (start[i] == 4'd9) begin
				nxt[i] = 4'd0;
			end else begin
				nxt[i] = start[i] + 4'd1;
				carry  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < EFF; i++)
				cnt_q[i] <= 4'd0;
		end else if (ctl.upd) begin
			for (int i = 0; i < EFF; i++)
				cnt_q[i] <= ctl.inc ? nxt[i] : start[i];
		end
	end

endmodule

// File: src/ctsf_checker.sv
module ctsf_checker (
	input logic        clk,
	input logic        arst_n,
	ctsf_in_if.sink    in_ch,
	ctsf_out_if.source out_ch
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid)
		else $error("output valid dropped while stalled");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("input stalled with nothing pending");

	a_more_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && !out_ch.last |=> out_ch.valid)
		else $error("output ended without last");

	a_ready_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready && out_ch.valid |-> out_ch.last && out_ch.ready)
		else $error("input taken while earlier bytes pending");

endmodule

bind cat_text_stream_formatter ctsf_checker u_ctsf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.in_ch  (in_ch),
	.out_ch (out_ch)
);

// File: bench/tb_cat_text_stream_formatter.sv
`timescale 1ns / 100ps

module tb_cat_text_stream_formatter;

	localparam int          DIGITS      = 6;
	localparam int          STALL_LIMIT = 2000;
	localparam int unsigned LINE_CEIL   = 999999;
	localparam int          N_PROBES    = 25;

	localparam logic [ctsf_pkg::NCFG-1:0] M_RAW = '0;
	localparam logic [ctsf_pkg::NCFG-1:0] M_NB  = 8'b1 << ctsf_pkg::CFG_NUMBER_NONBLANK;
	localparam logic [ctsf_pkg::NCFG-1:0] M_NA  = 8'b1 << ctsf_pkg::CFG_NUMBER_ALL;
	localparam logic [ctsf_pkg::NCFG-1:0] M_SQ  = 8'b1 << ctsf_pkg::CFG_SQUEEZE_BLANK;
	localparam logic [ctsf_pkg::NCFG-1:0] M_EN  = 8'b1 << ctsf_pkg::CFG_ENDS_AND_NONPRINT;
	localparam logic [ctsf_pkg::NCFG-1:0] M_EO  = 8'b1 << ctsf_pkg::CFG_ENDS_ONLY;
	localparam logic [ctsf_pkg::NCFG-1:0] M_TN  = 8'b1 << ctsf_pkg::CFG_TABS_AND_NONPRINT;
	localparam logic [ctsf_pkg::NCFG-1:0] M_TO  = 8'b1 << ctsf_pkg::CFG_TABS_ONLY;
	localparam logic [ctsf_pkg::NCFG-1:0] M_VN  = 8'b1 << ctsf_pkg::CFG_SHOW_NONPRINT;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_t;

	// n_typed == 0: expected text comes from format_byte
	typedef struct packed {
		logic [ctsf_pkg::NCFG-1:0] mode;
		logic [7:0]                ch;
		logic                      first;
		logic [2:0]                n_typed;
		logic [31:0]               typed;
	} probe_t;

	probe_t probes [0:N_PROBES-1] = '{
		'{M_RAW,             8'h00, 1'b1, 3'd1, 32'h00},
		'{M_RAW,             8'hFF, 1'b0, 3'd1, 32'hFF},
		'{M_RAW,             8'h0A, 1'b0, 3'd1, 32'h0A},
		'{M_VN,              8'h00, 1'b0, 3'd2, 32'h5E40},
		'{M_VN,              8'h7F, 1'b0, 3'd2, 32'h5E3F},
		'{M_VN,              8'hFF, 1'b0, 3'd2, 32'h5E3F},
		'{M_VN,              8'h80, 1'b0, 3'd2, 32'h5EC0},
		'{M_VN,              8'h09, 1'b0, 3'd1, 32'h09},
		'{M_TO,              8'h09, 1'b0, 3'd2, 32'h5E49},
		'{M_TO | M_EN,       8'h01, 1'b0, 3'd1, 32'h01},
		'{M_TO | M_VN,       8'h01, 1'b0, 3'd2, 32'h5E41},
		'{M_TN,              8'h1F, 1'b0, 3'd2, 32'h5E5F},
		'{M_EO,              8'h0A, 1'b0, 3'd2, 32'h240A},
		'{M_EN,              8'h1B, 1'b0, 3'd2, 32'h5E5B},
		'{M_EN,              8'h0A, 1'b0, 3'd2, 32'h240A},
		'{M_NA,              8'h61, 1'b1, 3'd0, 32'h0},
		'{M_NA,              8'h0A, 1'b0, 3'd0, 32'h0},
		'{M_NA,              8'h0A, 1'b0, 3'd0, 32'h0},
		'{M_NB | M_NA,       8'h0A, 1'b1, 3'd0, 32'h0},
		'{M_NB | M_NA,       8'h78, 1'b0, 3'd0, 32'h0},
		'{M_NA | M_SQ,       8'h0A, 1'b1, 3'd0, 32'h0},
		'{M_NA | M_SQ,       8'h0A, 1'b0, 3'd0, 32'h0},
		'{M_NA | M_SQ,       8'h0A, 1'b0, 3'd0, 32'h0},
		'{M_NA | M_SQ | M_EO, 8'h0A, 1'b1, 3'd0, 32'h0},
		'{M_NA | M_SQ | M_EO, 8'h7A, 1'b0, 3'd0, 32'h0}
	};

	logic clk = 1'b0;
	logic arst_n;

	logic done;
	int   errors;
	int   bytes_in;
	int   bytes_out;
	int   mode_sets;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	ctsf_in_if  in_ch ();
	ctsf_out_if out_ch ();
	ctsf_cfg_if cfg_ch ();

	cat_text_stream_formatter #(
		.NUMBER_DIGITS(DIGITS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch),
		.cfg   (cfg_ch)
	);

	// formatter state as seen by the checker
	logic [ctsf_pkg::NCFG-1:0] opt       = '0;
	logic [7:0]                prev_char = ctsf_pkg::CH_NL;
	int unsigned               line_no   = 0;
	logic [1:0]                blanks    = '0;
	logic [7:0]                line_bytes [$];
	text_t                     due_text [$];

	logic            calm  = 1'b0;
	int              quiet = 0;
	text_t           want;

	function automatic logic opt_on(input logic [ctsf_pkg::CFG_IDX_W-1:0] idx);
		return opt[idx[ctsf_pkg::CFG_SEL_W-1:0]];
	endfunction

	function automatic int unsigned line_cap();
		longint unsigned lim;
		int i;
		lim = 1;
		for (i = 0; i < DIGITS && lim <= LINE_CEIL; i++)
			lim = lim * 10;
		lim = lim - 1;
		return (lim > LINE_CEIL) ? LINE_CEIL : 32'(lim);
	endfunction

	function automatic void put_number();
		logic [7:0]  dig [DIGITS];
		int unsigned v;
		int          p;
		if (line_no < line_cap())
			line_no++;
		for (p = 0; p < DIGITS; p++)
			dig[p] = ctsf_pkg::CH_SPACE;
		v = line_no;
		p = DIGITS - 1;
		do begin
			dig[p] = ctsf_pkg::CH_ZERO + 8'(v % 10);
			v = v / 10;
			p--;
		end while (v != 0 && p >= 0);
		for (p = 0; p < DIGITS; p++)
			line_bytes.push_back(dig[p]);
		line_bytes.push_back(ctsf_pkg::CH_TAB);
	endfunction

	function automatic void put_shown(input logic [7:0] b);
		if ((b > ctsf_pkg::CTRL_MAX && b < ctsf_pkg::CH_DEL) || b == ctsf_pkg::CH_NL
				|| b == ctsf_pkg::CH_TAB) begin
			line_bytes.push_back(b);
		end else if (b == ctsf_pkg::CH_DEL) begin
			line_bytes.push_back(ctsf_pkg::CH_CARET);
			line_bytes.push_back(ctsf_pkg::CH_QMARK);
		end else begin
			line_bytes.push_back(ctsf_pkg::CH_CARET);
			line_bytes.push_back(b + ctsf_pkg::CARET_OFS);
		end
	endfunction

	function automatic void format_byte(input logic [7:0] b, input logic first);
		logic at_bol;
		logic ends;
		line_bytes = {};
		ends = opt_on(ctsf_pkg::CFG_ENDS_AND_NONPRINT) || opt_on(ctsf_pkg::CFG_ENDS_ONLY);
		if (first) begin
			prev_char = ctsf_pkg::CH_NL;
			line_no   = 0;
		end
		at_bol = (prev_char == ctsf_pkg::CH_NL);

		if (opt_on(ctsf_pkg::CFG_NUMBER_NONBLANK)) begin
			if (b != ctsf_pkg::CH_NL && (line_no == 0 || at_bol))
				put_number();
		end else if (opt_on(ctsf_pkg::CFG_NUMBER_ALL)) begin
			if (line_no == 0 || (at_bol && blanks < 2))
				put_number();
		end

		if (opt_on(ctsf_pkg::CFG_SQUEEZE_BLANK)) begin
			if (at_bol && b == ctsf_pkg::CH_NL) begin
				if (blanks < 3)
					blanks = blanks + 2'd1;
			end else begin
				blanks = 2'd0;
			end
			if (blanks == 1) begin
				if (ends)
					line_bytes.push_back(ctsf_pkg::CH_DOLLAR);
				line_bytes.push_back(ctsf_pkg::CH_NL);
			end
		end

		if (blanks == 0 || !opt_on(ctsf_pkg::CFG_SQUEEZE_BLANK)) begin
			if (ends && b == ctsf_pkg::CH_NL)
				line_bytes.push_back(ctsf_pkg::CH_DOLLAR);
			if (opt_on(ctsf_pkg::CFG_TABS_AND_NONPRINT) || opt_on(ctsf_pkg::CFG_TABS_ONLY)) begin
				if (b == ctsf_pkg::CH_TAB) begin
					line_bytes.push_back(ctsf_pkg::CH_CARET);
					line_bytes.push_back(ctsf_pkg::CH_I);
				end else if (opt_on(ctsf_pkg::CFG_TABS_ONLY)
						&& !opt_on(ctsf_pkg::CFG_SHOW_NONPRINT)) begin
					line_bytes.push_back(b);
				end else begin
					put_shown(b);
				end
			end else if (opt_on(ctsf_pkg::CFG_ENDS_AND_NONPRINT)
					|| opt_on(ctsf_pkg::CFG_SHOW_NONPRINT)) begin
				put_shown(b);
			end else begin
				line_bytes.push_back(b);
			end
			prev_char = b;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic first,
			input logic [2:0] n_typed, input logic [31:0] typed);
		text_t t;
		int    j;
		while (!calm && $urandom_range(99) < 19) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.data_byte     <= b;
		in_ch.first_of_file <= first;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		bytes_in++;
		format_byte(b, first);
		if (n_typed == 0) begin
			for (j = 0; j < line_bytes.size(); j++) begin
				t.ch   = line_bytes[j];
				t.last = (j == line_bytes.size() - 1);
				due_text.push_back(t);
			end
		end else begin
			for (j = n_typed - 1; j >= 0; j--) begin
				t.ch   = typed[8*j +: 8];
				t.last = (j == 0);
				due_text.push_back(t);
			end
		end
	endtask

	task automatic write_reg(input logic [ctsf_pkg::CFG_IDX_W-1:0] idx,
			input logic [ctsf_pkg::NCFG-1:0] m);
		logic val;
		val = m[idx[ctsf_pkg::CFG_SEL_W-1:0]];
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		opt[idx[ctsf_pkg::CFG_SEL_W-1:0]] = val;
	endtask

	// only while idle: drained, plus a wait for a byte that emits nothing
	task automatic set_mode(input logic [ctsf_pkg::NCFG-1:0] m);
		in_ch.valid <= 1'b0;
		while (due_text.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(ctsf_pkg::CFG_NUMBER_NONBLANK, m);
		write_reg(ctsf_pkg::CFG_NUMBER_ALL, m);
		write_reg(ctsf_pkg::CFG_SQUEEZE_BLANK, m);
		write_reg(ctsf_pkg::CFG_ENDS_AND_NONPRINT, m);
		write_reg(ctsf_pkg::CFG_ENDS_ONLY, m);
		write_reg(ctsf_pkg::CFG_TABS_AND_NONPRINT, m);
		write_reg(ctsf_pkg::CFG_TABS_ONLY, m);
		write_reg(ctsf_pkg::CFG_SHOW_NONPRINT, m);
		cfg_ch.valid <= 1'b0;
		mode_sets++;
	endtask

	initial begin
		int                        r;
		int                        ph;
		int                        k;
		logic [7:0]                b;
		logic [ctsf_pkg::NCFG-1:0] m;

		done                = 1'b0;
		errors              = 0;
		bytes_in            = 0;
		bytes_out           = 0;
		mode_sets           = 0;
		in_ch.valid         = 1'b0;
		in_ch.data_byte     = '0;
		in_ch.first_of_file = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = 1'b0;
		out_ch.ready        = 1'b0;

		do @(posedge clk); while (!arst_n);

		for (r = 0; r < N_PROBES; r++) begin
			if (r == 0 || probes[r].mode != opt)
				set_mode(probes[r].mode);
			send_byte(probes[r].ch, probes[r].first, probes[r].n_typed, probes[r].typed);
		end

		// long run of numbered lines, past the carry into the hundreds
		set_mode(M_NA);
		for (k = 0; k < 110; k++)
			send_byte(ctsf_pkg::CH_NL, k == 0, 3'd0, 32'h0);

		for (ph = 0; ph < 6; ph++) begin
			if (ph == 0)
				m = '1;
			else if (ph == 1)
				m = '0;
			else
				m = ctsf_pkg::NCFG'($urandom_range(255));
			set_mode(m);
			calm = (ph == 4);
			for (k = 0; k < 21; k++) begin
				case ($urandom_range(9))
					0, 1, 2: b = ctsf_pkg::CH_NL;
					3:       b = ctsf_pkg::CH_TAB;
					4:       b = 8'($urandom_range(255));
					5:       b = 8'($urandom_range(31));
					default: b = 8'($urandom_range(126, 32));
				endcase
				send_byte(b, $urandom_range(31) == 0, 3'd0, 32'h0);
			end
		end
		calm = 1'b0;

		in_ch.valid <= 1'b0;
		while (due_text.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		done = 1'b1;
	end

	always @(posedge clk)
		out_ch.ready <= calm || ($urandom_range(99) >= 19);

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			bytes_out++;
			if (due_text.size() == 0) begin
				errors++;
				$display("%0t: stray byte: expected none, actual %h last %b",
					$time, out_ch.out_byte, out_ch.last);
			end else begin
				want = due_text.pop_front();
				if (out_ch.out_byte !== want.ch) begin
					errors++;
					$display("%0t: out_byte: expected %h, actual %h",
						$time, want.ch, out_ch.out_byte);
				end
				if (out_ch.last !== want.last) begin
					errors++;
					$display("%0t: last: expected %b, actual %b",
						$time, want.last, out_ch.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (in_ch.valid && in_ch.ready)
				|| (out_ch.valid && out_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("%0t: watchdog, no transfer for too long", $time);
			$display("FAIL cat_text_stream_formatter");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait (done);
		$display("visibility table, a long numbered run and random option mixes with stalls");
		$display("%0d bytes in, %0d bytes out, %0d option sets",
			bytes_in, bytes_out, mode_sets);
		if (errors == 0)
			$display("PASS cat_text_stream_formatter");
		else
			$display("FAIL cat_text_stream_formatter");
		$finish;
	end

endmodule
